FILE: hw/rtl/sca_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes for the scanline cost aggregation block.
package sca_pkg;

   localparam int HALF_RANGE = 32;
   localparam int LEVELS     = 2 * HALF_RANGE;
   localparam int IDX_W      = 6;
   localparam logic [IDX_W-1:0] LEVEL_LAST = IDX_W'(LEVELS - 1);

   localparam int ACC_WIDTH = 24;
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;
   localparam int AGG_W     = 24;

   localparam int COST_W  = 10;
   localparam int PIX_W   = 8;
   localparam int PEN_W   = 16;
   localparam int SCALE_W = 8;
   localparam int THR_W   = 9;

   // Q4.4 scaling of the large penalty, rounded
   localparam int FRAC_W     = 4;
   localparam int PROD_W     = PEN_W + SCALE_W;
   localparam int P2_W       = PROD_W - FRAC_W;
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);

   // saturating sums are formed one bit wider than the widest operand
   localparam int SUM_W = ((ACC_WIDTH > P2_W) ? ACC_WIDTH : P2_W) + 1;

   // cost store: two banks (previous / current pixel) of 2**IDX_W entries
   localparam int ADDR_W = IDX_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMALL_PENALTY       = 2'd0,
      CSR_LARGE_PENALTY       = 2'd1,
      CSR_PENALTY_SCALE       = 2'd2,
      CSR_INTENSITY_THRESHOLD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PEN_W-1:0]   small_penalty;
      logic [PEN_W-1:0]   large_penalty;
      logic [SCALE_W-1:0] penalty_scale;
      logic [THR_W-1:0]   intensity_threshold;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic              root;
      logic              start;
      logic              last;
      logic              bank;
      logic [COST_W-1:0] cost;
      logic [PIX_W-1:0]  left;
      logic [PIX_W-1:0]  right;
   } item_type;

   typedef struct packed {
      logic load_a;
      logic adv_a;
      logic commit;
   } strobe_type;

   typedef struct packed {
      logic              a_valid;
      logic [ADDR_W-1:0] a_addr;
      logic              b_valid;
      logic [ADDR_W-1:0] b_addr;
   } flight_type;

endpackage

FILE: hw/rtl/sca_cost_ram.sv
`timescale 1ns / 1ps
// Two-bank cost store: one write port, two registered read ports.
module sca_cost_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [sca_pkg::ADDR_W-1:0]       wr_addr,
   input  logic [sca_pkg::ACC_WIDTH-1:0]    wr_data,
   input  logic                             rd_en,
   input  logic [sca_pkg::ADDR_W-1:0]       rd_addr_a,
   input  logic [sca_pkg::ADDR_W-1:0]       rd_addr_b,
   output logic [sca_pkg::ACC_WIDTH-1:0]    rd_data_a_ff,
   output logic [sca_pkg::ACC_WIDTH-1:0]    rd_data_b_ff
);
   import sca_pkg::*;

   logic [ACC_WIDTH-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

endmodule

FILE: hw/rtl/sca_sequencer.sv
`timescale 1ns / 1ps
// Level counter, path root flag, bank select, read addressing and store interlock.
module sca_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [sca_pkg::COST_W-1:0]    req_match_cost,
   input  logic [sca_pkg::PIX_W-1:0]     req_left_intensity,
   input  logic [sca_pkg::PIX_W-1:0]     req_right_intensity,
   input  logic                          req_line_start,
   input  sca_pkg::flight_type           flight,
   output sca_pkg::item_type             item,
   output logic [sca_pkg::ADDR_W-1:0]    rd_addr_same,
   output logic [sca_pkg::ADDR_W-1:0]    rd_addr_next,
   output logic                          hazard
);
   import sca_pkg::*;

   logic [IDX_W-1:0] count_ff, count_in;
   logic             root_ff, root_in;
   logic             bank_ff, bank_in;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] idx_next;

   always_comb begin
      idx        = req_line_start ? '0 : count_ff;
      idx_next   = idx + IDX_W'(1);

      item.idx   = idx;
      item.start = req_line_start;
      item.root  = req_line_start | root_ff;
      item.last  = (idx == LEVEL_LAST);
      item.bank  = bank_ff;
      item.cost  = req_match_cost;
      item.left  = req_left_intensity;
      item.right = req_right_intensity;

      // previous pixel lives in the other bank
      rd_addr_same = {~bank_ff, idx};
      rd_addr_next = {~bank_ff, idx_next};

      // hold off while a pending write targets an entry this item reads
      hazard = (flight.a_valid && (flight.a_addr == rd_addr_same ||
                                   flight.a_addr == rd_addr_next)) ||
               (flight.b_valid && (flight.b_addr == rd_addr_same ||
                                   flight.b_addr == rd_addr_next));

      count_in = count_ff;
      root_in  = root_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (item.last) begin
            count_in = '0;
            root_in  = 1'b0;
            bank_in  = ~bank_ff;
         end else begin
            count_in = idx_next;
            root_in  = item.root;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         root_ff  <= 1'b1;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         root_ff  <= root_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

FILE: hw/rtl/sca_datapath.sv
`timescale 1ns / 1ps
// Two-stage recurrence: neighbor minimum, then penalty, cost add and running minimum.
module sca_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sca_pkg::cfg_type              cfg,
   input  sca_pkg::strobe_type           strobe,
   input  sca_pkg::item_type             item_in,
   input  logic [sca_pkg::ACC_WIDTH-1:0] rd_same,
   input  logic [sca_pkg::ACC_WIDTH-1:0] rd_next,
   output logic [sca_pkg::ADDR_W-1:0]    a_addr,
   output logic [sca_pkg::ADDR_W-1:0]    b_addr,
   output sca_pkg::item_type             b_item,
   output logic [sca_pkg::ACC_WIDTH-1:0] agg
);
   import sca_pkg::*;

   function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = a + b;
      return (s > SUM_W'(ACC_MAX)) ? ACC_MAX : s[ACC_WIDTH-1:0];
   endfunction

   item_type             a_item_ff, b_item_ff;
   logic [ACC_WIDTH-1:0] left_nb_ff;
   logic [ACC_WIDTH-1:0] mem_best_ff, mem_best_in;
   logic [ACC_WIDTH-1:0] prev_min_ff, prev_min_in;
   logic [ACC_WIDTH-1:0] run_min_ff, run_min_in;
   logic [PIX_W-1:0]     prev_left_ff, prev_left_in;
   logic [PIX_W-1:0]     prev_right_ff, prev_right_in;
   logic [P2_W-1:0]      p2_ff, p2_in;

   logic [ACC_WIDTH-1:0] s_lo, s_hi, pen, best, base, new_min;
   logic [PIX_W-1:0]     diff;
   logic [PROD_W-1:0]    rounded;

   // stage A: same level and the two neighbor levels of the previous pixel
   always_comb begin
      s_lo = sat_add(SUM_W'(left_nb_ff), SUM_W'(cfg.small_penalty));
      s_hi = sat_add(SUM_W'(rd_next), SUM_W'(cfg.small_penalty));
      mem_best_in = rd_same;
      if (a_item_ff.idx != '0 && s_lo < mem_best_in) begin
         mem_best_in = s_lo;
      end
      if (a_item_ff.idx != LEVEL_LAST && s_hi < mem_best_in) begin
         mem_best_in = s_hi;
      end
   end

   // stage B: jump penalty, cost add, running minimum
   always_comb begin
      pen  = sat_add(SUM_W'(prev_min_ff), SUM_W'(p2_ff));
      best = (mem_best_ff < pen) ? mem_best_ff : pen;
      agg  = b_item_ff.root ? ACC_WIDTH'(b_item_ff.cost)
                            : sat_add(SUM_W'(b_item_ff.cost), SUM_W'(best));
      base    = b_item_ff.start ? ACC_MAX : run_min_ff;
      new_min = (agg < base) ? agg : base;

      prev_min_in   = prev_min_ff;
      run_min_in    = run_min_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      if (strobe.commit) begin
         if (b_item_ff.last) begin
            prev_min_in   = new_min;
            run_min_in    = ACC_MAX;
            prev_left_in  = b_item_ff.left;
            prev_right_in = b_item_ff.right;
         end else begin
            run_min_in = new_min;
         end
      end

      // P2 follows the intensities that the next pixel will see
      diff    = (prev_left_in > prev_right_in) ? prev_left_in - prev_right_in
                                               : prev_right_in - prev_left_in;
      rounded = PROD_W'(cfg.large_penalty) * PROD_W'(cfg.penalty_scale) + ROUND_BIAS;
      p2_in   = ({1'b0, diff} < cfg.intensity_threshold) ? rounded[PROD_W-1:FRAC_W]
                                                         : P2_W'(cfg.large_penalty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_min_ff   <= ACC_MAX;
         run_min_ff    <= ACC_MAX;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
      end else begin
         prev_min_ff   <= prev_min_in;
         run_min_ff    <= run_min_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
      end
   end

   always_ff @(posedge clock) begin
      p2_ff <= p2_in;
      if (strobe.load_a) begin
         a_item_ff <= item_in;
      end
      if (strobe.adv_a) begin
         b_item_ff   <= a_item_ff;
         mem_best_ff <= mem_best_in;
         left_nb_ff  <= rd_same;
      end
   end

   assign a_addr = {a_item_ff.bank, a_item_ff.idx};
   assign b_addr = {b_item_ff.bank, b_item_ff.idx};
   assign b_item = b_item_ff;

endmodule

FILE: hw/rtl/scanline_cost_aggregation.sv
`timescale 1ns / 1ps
// Top level of the scanline cost aggregation block.
//
// One aggregation path of semi-global matching. The request channel (req_) carries one
// matching cost per disparity level, levels in order, with the pixel's left and right
// intensities; req_line_start marks the first level of the first pixel of a path.
// The response channel (rsp_) returns one aggregated cost per request transaction,
// in order, tagged with its disparity level and a last-level flag. The user must write
// penalty registers (csr_ port) only while the block is idle; the block never checks.
//
// Throughput: one transaction per cycle while rsp_ready stays high. A request passes
// store read, neighbor minimum, then penalty add / output on its way to the response.
// The previous and current pixel costs share one memory, banked, with two read
// ports and one write port; a read that would hit a write still in flight holds
// req_ready low until that write lands (not hit with 64 levels).
// When rsp_ready is low the output register holds and the two inner stages keep
// filling; req_ready drops once all three are occupied.
// Synchronous reset clears the pipeline, marks the next pixel as a path root and
// restores the register defaults. The memory needs no clearing.
module scanline_cost_aggregation (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sca_pkg::COST_W-1:0]        req_match_cost,
   input  logic [sca_pkg::PIX_W-1:0]         req_left_intensity,
   input  logic [sca_pkg::PIX_W-1:0]         req_right_intensity,
   input  logic                              req_line_start,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sca_pkg::AGG_W-1:0]         rsp_aggregated_cost,
   output logic [sca_pkg::IDX_W-1:0]         rsp_disparity_index,
   output logic                              rsp_last_of_pixel,

   input  logic                              csr_write_enable,
   input  logic [sca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sca_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import sca_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SMALL_PENALTY:       cfg_in.small_penalty       = csr_write_data;
            CSR_LARGE_PENALTY:       cfg_in.large_penalty       = csr_write_data;
            CSR_PENALTY_SCALE:       cfg_in.penalty_scale       = csr_write_data[SCALE_W-1:0];
            CSR_INTENSITY_THRESHOLD: cfg_in.intensity_threshold = csr_write_data[THR_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.small_penalty       <= PEN_W'(20);
         cfg_ff.large_penalty       <= PEN_W'(200);
         cfg_ff.penalty_scale       <= SCALE_W'(16);
         cfg_ff.intensity_threshold <= THR_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline occupancy: stage A (store read data), stage B, output register
   logic a_v_ff, a_v_in;
   logic b_v_ff, b_v_in;
   logic out_v_ff, out_v_in;
   logic out_free, b_free, a_free;
   logic a_fire, b_fire, accept;
   logic hazard;

   assign out_free  = !out_v_ff || rsp_ready;
   assign b_fire    = b_v_ff && out_free;
   assign b_free    = !b_v_ff || out_free;
   assign a_fire    = a_v_ff && b_free;
   assign a_free    = !a_v_ff || b_free;
   assign req_ready = a_free && !hazard;
   assign accept    = req_valid && req_ready;

   assign a_v_in   = accept || (a_v_ff && !b_free);
   assign b_v_in   = a_fire || (b_v_ff && !out_free);
   assign out_v_in = b_fire || (out_v_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         a_v_ff   <= a_v_in;
         b_v_ff   <= b_v_in;
         out_v_ff <= out_v_in;
      end
   end

   item_type             item;
   item_type             b_item;
   flight_type           flight;
   strobe_type           strobe;
   logic [ADDR_W-1:0]    rd_addr_same, rd_addr_next;
   logic [ADDR_W-1:0]    a_addr, b_addr;
   logic [ACC_WIDTH-1:0] rd_same, rd_next, agg;

   assign flight.a_valid = a_v_ff;
   assign flight.a_addr  = a_addr;
   assign flight.b_valid = b_v_ff;
   assign flight.b_addr  = b_addr;

   assign strobe.load_a = accept;
   assign strobe.adv_a  = a_fire;
   assign strobe.commit = b_fire;

   sca_sequencer u_sequencer (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_match_cost      (req_match_cost),
      .req_left_intensity  (req_left_intensity),
      .req_right_intensity (req_right_intensity),
      .req_line_start      (req_line_start),
      .flight              (flight),
      .item                (item),
      .rd_addr_same        (rd_addr_same),
      .rd_addr_next        (rd_addr_next),
      .hazard              (hazard)
   );

   // store write happens as the result leaves stage B
   sca_cost_ram u_cost_ram (
      .clock        (clock),
      .wr_en        (b_fire),
      .wr_addr      (b_addr),
      .wr_data      (agg),
      .rd_en        (accept),
      .rd_addr_a    (rd_addr_same),
      .rd_addr_b    (rd_addr_next),
      .rd_data_a_ff (rd_same),
      .rd_data_b_ff (rd_next)
   );

   sca_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .strobe   (strobe),
      .item_in  (item),
      .rd_same  (rd_same),
      .rd_next  (rd_next),
      .a_addr   (a_addr),
      .b_addr   (b_addr),
      .b_item   (b_item),
      .agg      (agg)
   );

   // output register
   logic [AGG_W-1:0] out_agg_ff;
   logic [IDX_W-1:0] out_idx_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (b_fire) begin
         out_agg_ff  <= AGG_W'(agg);
         out_idx_ff  <= b_item.idx;
         out_last_ff <= b_item.last;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_aggregated_cost = out_agg_ff;
   assign rsp_disparity_index = out_idx_ff;
   assign rsp_last_of_pixel   = out_last_ff;

`ifndef NO_ASSERTIONS
   // a read never lands on an entry that is being written in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (b_fire && accept) |-> (b_addr != rd_addr_same && b_addr != rd_addr_next))
      else $error("cost store read collides with write");

   // the last-level flag agrees with the level index on every response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_pixel == (rsp_disparity_index == LEVEL_LAST)))
      else $error("last_of_pixel does not match disparity index");

   // a transaction accepted while stage B is stalled keeps stage A occupied
   assert property (@(posedge clock) disable iff (reset)
      (accept && b_v_ff && !out_free) |=> (a_v_ff && b_v_ff))
      else $error("stalled pipeline lost a transaction");
`endif

endmodule

FILE: tb/sca_tb_pkg.sv
`timescale 1ns / 1ps
// Expected-cost tracker for the scanline cost aggregation testbench.
package sca_tb_pkg;
   import sca_pkg::*;

   typedef struct {
      bit [AGG_W-1:0] cost;
      bit [IDX_W-1:0] level;
      bit             last;
   } path_result_type;

   // penalty width after Q4.4 scaling plus rounding headroom
   localparam int SCALED_W = PEN_W + SCALE_W + 1;

   // operand width of the saturating add: one bit over the accumulator
   localparam int SAT_ARG_W = ACC_WIDTH + 1;

   class path_aggregate_tracker;
      bit [PEN_W-1:0]     small_pen;
      bit [PEN_W-1:0]     large_pen;
      bit [SCALE_W-1:0]   pen_scale;
      bit [THR_W-1:0]     diff_limit;

      bit [ACC_WIDTH-1:0] last_pixel_cost [LEVELS];
      bit [ACC_WIDTH-1:0] this_pixel_cost [LEVELS];
      bit [ACC_WIDTH-1:0] last_pixel_min;
      bit [ACC_WIDTH-1:0] this_pixel_min;
      bit [PIX_W-1:0]     last_left;
      bit [PIX_W-1:0]     last_right;
      bit [IDX_W-1:0]     level;
      bit                 path_root;

      path_result_type    expected_costs [$];
      int                 failures;

      function new();
         small_pen  = 16'd20;
         large_pen  = 16'd200;
         pen_scale  = 8'd16;
         diff_limit = 9'd10;
         foreach (last_pixel_cost[i]) begin
            last_pixel_cost[i] = '0;
            this_pixel_cost[i] = '0;
         end
         last_pixel_min = ACC_MAX;
         this_pixel_min = ACC_MAX;
         last_left      = '0;
         last_right     = '0;
         level          = '0;
         path_root      = 1'b1;
         failures       = 0;
      endfunction

      function void set_register(csr_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_SMALL_PENALTY:       small_pen  = value[PEN_W-1:0];
            CSR_LARGE_PENALTY:       large_pen  = value[PEN_W-1:0];
            CSR_PENALTY_SCALE:       pen_scale  = value[SCALE_W-1:0];
            CSR_INTENSITY_THRESHOLD: diff_limit = value[THR_W-1:0];
            default: ;
         endcase
      endfunction

      static function bit [ACC_WIDTH-1:0] saturating_add(bit [SAT_ARG_W-1:0] a,
                                                         bit [SAT_ARG_W-1:0] b);
         bit [ACC_WIDTH+1:0] total;
         total = a + b;
         return (total > ACC_MAX) ? ACC_MAX : total[ACC_WIDTH-1:0];
      endfunction

      // one accepted request: compute its aggregated cost and queue it
      function void accept_cost(bit [COST_W-1:0] cost, bit [PIX_W-1:0] left,
                                bit [PIX_W-1:0] right, bit start);
         bit [ACC_WIDTH-1:0] best;
         bit [ACC_WIDTH-1:0] alt;
         bit [ACC_WIDTH-1:0] agg;
         bit [PIX_W-1:0]     diff;
         bit [SCALED_W-1:0]  scaled;
         bit [SCALED_W-1:0]  jump_pen;
         path_result_type    res;

         if (start) begin
            level          = '0;
            path_root      = 1'b1;
            this_pixel_min = ACC_MAX;
         end

         if (path_root) begin
            agg = ACC_WIDTH'(cost);
         end else begin
            diff = (last_left > last_right) ? last_left - last_right
                                            : last_right - last_left;
            scaled   = SCALED_W'(large_pen) * SCALED_W'(pen_scale) + SCALED_W'(8);
            jump_pen = ({1'b0, diff} < diff_limit) ? (scaled >> 4) : SCALED_W'(large_pen);
            best = last_pixel_cost[level];
            alt  = saturating_add(SAT_ARG_W'(last_pixel_min), SAT_ARG_W'(jump_pen));
            if (alt < best) best = alt;
            if (level != 0) begin
               alt = saturating_add(SAT_ARG_W'(last_pixel_cost[level - 1]),
                                    SAT_ARG_W'(small_pen));
               if (alt < best) best = alt;
            end
            if (level != LEVEL_LAST) begin
               alt = saturating_add(SAT_ARG_W'(last_pixel_cost[level + 1]),
                                    SAT_ARG_W'(small_pen));
               if (alt < best) best = alt;
            end
            agg = saturating_add(SAT_ARG_W'(cost), SAT_ARG_W'(best));
         end

         this_pixel_cost[level] = agg;
         if (agg < this_pixel_min) this_pixel_min = agg;

         res.cost  = agg[AGG_W-1:0];
         res.level = level;
         res.last  = (level == LEVEL_LAST);
         expected_costs.push_back(res);

         if (res.last) begin
            last_pixel_cost = this_pixel_cost;
            last_pixel_min  = this_pixel_min;
            this_pixel_min  = ACC_MAX;
            last_left       = left;
            last_right      = right;
            path_root       = 1'b0;
            level           = '0;
         end else begin
            level = level + 1'b1;
         end
      endfunction

      function void flag(string field, longint unsigned want, logic [31:0] got);
         failures++;
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
      endfunction

      // one accepted response: compare against the oldest expected cost
      function void match_response(logic [AGG_W-1:0] cost, logic [IDX_W-1:0] lvl,
                                   logic last);
         path_result_type want;
         if (expected_costs.size() == 0) begin
            failures++;
            $error("response with no request outstanding: cost %0d level %0d",
                   cost, lvl);
            return;
         end
         want = expected_costs.pop_front();
         if (cost !== want.cost)  flag("aggregated_cost", want.cost, cost);
         if (lvl !== want.level)  flag("disparity_index", want.level, lvl);
         if (last !== want.last)  flag("last_of_pixel", want.last, last);
      endfunction

      function int pending();
         return expected_costs.size();
      endfunction
   endclass

endpackage

FILE: tb/tb_scanline_cost_aggregation.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scanline cost aggregation block.
module tb_scanline_cost_aggregation;
   import sca_pkg::*;
   import sca_tb_pkg::*;

   localparam int IDLE_PCT     = 12;    // chance in 100 that a side idles in a cycle
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int STALL_LIMIT  = 4000;  // cycles without any transaction
   localparam int PHASE_ITEMS  = 260;   // random requests per penalty setting
   localparam int PHASES       = 6;
   localparam int CSR_SETTLE   = 4;     // idle cycles before touching registers
   localparam int END_SETTLE   = 8;

   typedef enum int {COST_UNIFORM, COST_LOW, COST_EXTREME} cost_style_type;

   logic                    clock;
   logic                    reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [COST_W-1:0]       req_match_cost = '0;
   logic [PIX_W-1:0]        req_left_intensity = '0;
   logic [PIX_W-1:0]        req_right_intensity = '0;
   logic                    req_line_start = 1'b0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [AGG_W-1:0]        rsp_aggregated_cost;
   logic [IDX_W-1:0]        rsp_disparity_index;
   logic                    rsp_last_of_pixel;

   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   path_aggregate_tracker   tracker = new();

   bit                      calm = 1'b0;          // no idling on either side
   bit                      hold_request = 1'b0;  // ask the sink for a long hold-off
   int                      quiet_cycles = 0;

   scanline_cost_aggregation uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_match_cost      (req_match_cost),
      .req_left_intensity  (req_left_intensity),
      .req_right_intensity (req_right_intensity),
      .req_line_start      (req_line_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_aggregated_cost (rsp_aggregated_cost),
      .rsp_disparity_index (rsp_disparity_index),
      .rsp_last_of_pixel   (rsp_last_of_pixel),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Watchdog: a run that stops moving is a failure.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, tracker.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Response sink. Samples the handshake right after the edge (values
   // from before the edge), then decides rsp_ready for the next cycle.
   // A hold-off request from the stimulus side parks rsp_ready low for
   // HOLD_CYCLES so the pipeline fills and back-pressures req_ready.
   // ------------------------------------------------------------------
   initial begin : response_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            tracker.match_response(rsp_aggregated_cost, rsp_disparity_index,
                                   rsp_last_of_pixel);
         if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request driver. Called right after a rising edge; returns at the
   // edge where the transaction is accepted, with req_valid still high
   // so back-to-back transactions need only one assignment per step.
   // ------------------------------------------------------------------
   task automatic send_item(input logic [COST_W-1:0] cost, input logic [PIX_W-1:0] left,
                            input logic [PIX_W-1:0] right, input logic start);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_match_cost      <= cost;
      req_left_intensity  <= left;
      req_right_intensity <= right;
      req_line_start      <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.accept_cost(cost, left, right, start);
   endtask

   // drop valid and wait until every queued response is back, then a short pause
   task automatic wait_until_idle(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // drives one register write; the caller lowers the enable after the last one
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic program_penalties(input cfg_type c);
      write_register(CSR_SMALL_PENALTY, c.small_penalty);
      write_register(CSR_LARGE_PENALTY, c.large_penalty);
      write_register(CSR_PENALTY_SCALE, CSR_DATA_W'(c.penalty_scale));
      write_register(CSR_INTENSITY_THRESHOLD, CSR_DATA_W'(c.intensity_threshold));
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [COST_W-1:0] pick_cost(cost_style_type style);
      case (style)
         COST_LOW:     return COST_W'($urandom_range(15));
         COST_EXTREME: return $urandom_range(1) ? {COST_W{1'b1}} : {COST_W{1'b0}};
         default:      return COST_W'($urandom_range((1 << COST_W) - 1));
      endcase
   endfunction

   // Intensity pair: equal, close (straddles typical thresholds) or unrelated.
   task automatic pick_intensities(output logic [PIX_W-1:0] left,
                                   output logic [PIX_W-1:0] right);
      left = PIX_W'($urandom_range(255));
      case ($urandom_range(2))
         0:       right = left;
         1:       right = left ^ PIX_W'($urandom_range(15));
         default: right = PIX_W'($urandom_range(255));
      endcase
   endtask

   // One pixel: 'length' levels in order. A short pixel is the broken case;
   // some pixels change intensities from level to level.
   task automatic send_pixel(input bit path_head, input int length);
      logic [PIX_W-1:0] left;
      logic [PIX_W-1:0] right;
      cost_style_type   style;
      bit               vary;
      style = cost_style_type'($urandom_range(9) < 6 ? COST_UNIFORM :
                               ($urandom_range(2) == 0 ? COST_EXTREME : COST_LOW));
      vary  = ($urandom_range(4) == 0);
      pick_intensities(left, right);
      for (int lv = 0; lv < length; lv++) begin
         if (vary) pick_intensities(left, right);
         send_item(pick_cost(style), left, right, path_head && lv == 0);
      end
   endtask

   // Mostly whole pixels grouped into paths of random length; a truncated
   // pixel is always followed by a fresh path start.
   task automatic run_paths(input int budget);
      int  sent;
      int  length;
      bit  head;
      sent = 0;
      head = 1'b1;
      while (sent < budget) begin
         length = ($urandom_range(11) == 0) ? $urandom_range(1, LEVELS - 1) : LEVELS;
         send_pixel(head, length);
         sent += length;
         head = (length != LEVELS) || ($urandom_range(3) == 0);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      cfg_type setting [PHASES];

      // phase 0 runs on the reset values of the penalty registers
      setting[1] = '{small_penalty: '0, large_penalty: '0, penalty_scale: '0,
                     intensity_threshold: '0};
      setting[2] = '{small_penalty: '1, large_penalty: '1, penalty_scale: '1,
                     intensity_threshold: THR_W'(256)};
      setting[3] = '{small_penalty: PEN_W'($urandom_range(65535)),
                     large_penalty: PEN_W'($urandom_range(65535)),
                     penalty_scale: SCALE_W'($urandom_range(255)),
                     intensity_threshold: THR_W'(256)};
      setting[4] = '{small_penalty: PEN_W'($urandom_range(65535)),
                     large_penalty: PEN_W'($urandom_range(65535)),
                     penalty_scale: SCALE_W'($urandom_range(255)),
                     intensity_threshold: THR_W'($urandom_range(256))};
      setting[5] = '{small_penalty: PEN_W'($urandom_range(63)),
                     large_penalty: PEN_W'($urandom_range(1023)),
                     penalty_scale: SCALE_W'($urandom_range(255)),
                     intensity_threshold: THR_W'($urandom_range(256))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and path restarts, including restarts in
      // mid-pixel and back to back. All of these are path roots, so the
      // result is the matching cost itself.
      send_item(10'd0,    8'd0,   8'd255, 1'b1);
      send_item(10'd1023, 8'd255, 8'd0,   1'b0);
      send_item(10'h2AA,  8'hAA,  8'h55,  1'b0);
      send_item(10'h155,  8'h55,  8'hAA,  1'b0);
      send_item(10'd1,    8'd1,   8'd254, 1'b1);
      send_item(10'd1022, 8'd254, 8'd1,   1'b1);
      send_item(10'd512,  8'd128, 8'd127, 1'b0);
      send_item(10'd511,  8'd127, 8'd128, 1'b0);
      send_item(10'd1023, 8'd255, 8'd255, 1'b1);
      send_item(10'd0,    8'd0,   8'd0,   1'b0);
      send_item(10'd1023, 8'd0,   8'd0,   1'b0);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            // registers change only with the pipeline empty
            wait_until_idle(CSR_SETTLE);
            program_penalties(setting[p]);
         end
         // one stretch with no idling on either side
         calm = (p == 3);
         // fill the pipeline against a stalled sink
         if (p == 4) hold_request = 1'b1;
         run_paths(PHASE_ITEMS);
      end

      wait_until_idle(END_SETTLE);
      if (tracker.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/sca_pkg.sv
hw/rtl/sca_cost_ram.sv
hw/rtl/sca_sequencer.sv
hw/rtl/sca_datapath.sv
hw/rtl/scanline_cost_aggregation.sv
tb/sca_tb_pkg.sv
tb/tb_scanline_cost_aggregation.sv
